// ===== hdl/tbo_pkg.sv =====
// ----------------------------------------------------------------------------
// tbo_pkg
// Widths, register indexes and axis helpers shared by the triangle/box
// overlap pipeline.
// ----------------------------------------------------------------------------
package tbo_pkg;

  localparam int CW  = 32;            // coordinate width
  localparam int HW  = CW - 1;        // half extent width (unsigned)
  localparam int VW  = CW + 1;        // vertex relative to box center
  localparam int EW  = CW + 2;        // edge vector
  localparam int BW  = CW + 2;        // bounding range compare
  localparam int PPW = EW + VW;       // edge by vertex product
  localparam int RW  = EW + HW;       // radius product (unsigned)
  localparam int NPW = 2 * EW;        // edge by edge product
  localparam int WW  = 2 * CW + 5;    // projections, radius, normal
  localparam int NL  = CW + 3;        // low slice of the normal
  localparam int NHW = WW - NL;       // high slice of the normal
  localparam int LW  = NL + 1 + EW;   // low partial product
  localparam int HPW = NHW + EW;      // high partial product
  localparam int DW  = 3 * CW + 9;    // plane distance sums

  localparam int IW = 2;              // register index width

  typedef enum logic [IW-1:0] {
    REG_HALF_X = 2'd0,
    REG_HALF_Y = 2'd1,
    REG_HALF_Z = 2'd2
  } reg_idx_t;

  // the two other axes of axis k
  function automatic int unsigned ax1(input int unsigned k);
    return (k == 2) ? 0 : k + 1;
  endfunction

  function automatic int unsigned ax2(input int unsigned k);
    return (k == 0) ? 2 : k - 1;
  endfunction

endpackage

// ===== hdl/triangle_box_overlap_test.sv =====
// ----------------------------------------------------------------------------
// triangle_box_overlap_test
// Separating-axis test of one triangle against one axis-aligned box per word.
//
//   channel | ports                         | dir | handshake
//   in      | in_a_x .. in_center_z         | in  | in_valid / in_ready
//   out     | out_overlap                   | out | out_valid / out_ready
//   cfg     | cfg_index, cfg_wdata          | in  | cfg_we, no wait
//
// One word enters per cycle while the output word is not waiting.
// Six register stages: offsets, edges, products, differences, edge compares
// with split normal products, plane sums into the output register.
// The whole pipeline holds while the output word waits; nothing is lost.
// Synchronous active-low reset clears the valid bits and sets each half
// extent to 0.5.
// ----------------------------------------------------------------------------
module triangle_box_overlap_test (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [tbo_pkg::CW-1:0] in_a_x,
  input  logic signed [tbo_pkg::CW-1:0] in_a_y,
  input  logic signed [tbo_pkg::CW-1:0] in_a_z,
  input  logic signed [tbo_pkg::CW-1:0] in_b_x,
  input  logic signed [tbo_pkg::CW-1:0] in_b_y,
  input  logic signed [tbo_pkg::CW-1:0] in_b_z,
  input  logic signed [tbo_pkg::CW-1:0] in_c_x,
  input  logic signed [tbo_pkg::CW-1:0] in_c_y,
  input  logic signed [tbo_pkg::CW-1:0] in_c_z,
  input  logic signed [tbo_pkg::CW-1:0] in_center_x,
  input  logic signed [tbo_pkg::CW-1:0] in_center_y,
  input  logic signed [tbo_pkg::CW-1:0] in_center_z,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_overlap,
  input  logic                        cfg_we,
  input  logic [tbo_pkg::IW-1:0]      cfg_index,
  input  logic [tbo_pkg::HW-1:0]      cfg_wdata
);
  import tbo_pkg::*;

  logic [HW-1:0] half_r [3];
  logic          en;

  logic vld1_r, vld2_r, vld3_r, vld4_r, vld5_r, out_valid_r, out_overlap_r;

  logic signed [CW-1:0]  vin [3][3];
  logic signed [CW-1:0]  cin [3];
  logic signed [VW-1:0]  v1_nxt [3][3];
  logic signed [VW-1:0]  v1_r [3][3];
  logic signed [VW-1:0]  v2_r [3][3];
  logic signed [EW-1:0]  e2_r [3][3];
  logic                  box2_r;
  logic                  box2_nxt;
  logic signed [PPW-1:0] pa3_r [3][3][3];
  logic signed [PPW-1:0] pb3_r [3][3][3];
  logic [RW-1:0]         ra3_r [3][3];
  logic [RW-1:0]         rb3_r [3][3];
  logic signed [NPW-1:0] na3_r [3];
  logic signed [NPW-1:0] nb3_r [3];
  logic signed [VW-1:0]  v03_r [3];
  logic                  box3_r;
  logic signed [WW-1:0]  p4_r [3][3][3];
  logic signed [WW-1:0]  rad4_r [3][3];
  logic signed [WW-1:0]  nrm4_r [3];
  logic signed [EW-1:0]  lo4_r [3];
  logic signed [EW-1:0]  hi4_r [3];
  logic                  box4_r;
  logic                  edge5_nxt, edge5_r, box5_r, nz5_r;
  logic signed [LW-1:0]  mll5_r [3];
  logic signed [HPW-1:0] mlh5_r [3];
  logic signed [LW-1:0]  mhl5_r [3];
  logic signed [HPW-1:0] mhh5_r [3];
  logic signed [DW-1:0]  dmin_nxt, dmax_nxt;

  assign en        = !out_valid_r || out_ready;
  assign in_ready  = en;
  assign out_valid = out_valid_r;
  assign out_overlap = out_overlap_r;

  // half extents
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r[0] <= HW'(32768);
      half_r[1] <= HW'(32768);
      half_r[2] <= HW'(32768);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HALF_X: half_r[0] <= cfg_wdata;
        REG_HALF_Y: half_r[1] <= cfg_wdata;
        REG_HALF_Z: half_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r      <= 1'b0;
      vld2_r      <= 1'b0;
      vld3_r      <= 1'b0;
      vld4_r      <= 1'b0;
      vld5_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld1_r      <= in_valid;
      vld2_r      <= vld1_r;
      vld3_r      <= vld2_r;
      vld4_r      <= vld3_r;
      vld5_r      <= vld4_r;
      out_valid_r <= vld5_r;
    end
  end

  // stage 1: vertices relative to box center
  always_comb begin
    vin[0][0] = in_a_x; vin[0][1] = in_a_y; vin[0][2] = in_a_z;
    vin[1][0] = in_b_x; vin[1][1] = in_b_y; vin[1][2] = in_b_z;
    vin[2][0] = in_c_x; vin[2][1] = in_c_y; vin[2][2] = in_c_z;
    cin[0] = in_center_x; cin[1] = in_center_y; cin[2] = in_center_z;
    for (int n = 0; n < 3; n++) begin
      for (int q = 0; q < 3; q++) begin
        v1_nxt[n][q] = VW'(vin[n][q]) - VW'(cin[q]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v1_r <= v1_nxt;
    end
  end

  // stage 2: edges and bounding range test
  always_comb begin
    logic all_hi, all_lo;
    box2_nxt = 1'b0;
    for (int q = 0; q < 3; q++) begin
      all_hi = 1'b1;
      all_lo = 1'b1;
      for (int n = 0; n < 3; n++) begin
        all_hi = all_hi && (BW'(v1_r[n][q]) > $signed(BW'(half_r[q])));
        all_lo = all_lo && (BW'(v1_r[n][q]) < -$signed(BW'(half_r[q])));
      end
      box2_nxt = box2_nxt || all_hi || all_lo;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v2_r   <= v1_r;
      box2_r <= box2_nxt;
      for (int q = 0; q < 3; q++) begin
        e2_r[0][q] <= EW'(v1_r[1][q]) - EW'(v1_r[0][q]);
        e2_r[1][q] <= EW'(v1_r[2][q]) - EW'(v1_r[1][q]);
        e2_r[2][q] <= EW'(v1_r[0][q]) - EW'(v1_r[2][q]);
      end
    end
  end

  // stage 3: products
  always_ff @(posedge clk) begin
    logic [EW-1:0] ae_i, ae_j;
    if (en) begin
      box3_r <= box2_r;
      for (int q = 0; q < 3; q++) begin
        v03_r[q] <= v2_r[0][q];
        na3_r[q] <= e2_r[0][ax1(q)] * e2_r[1][ax2(q)];
        nb3_r[q] <= e2_r[0][ax2(q)] * e2_r[1][ax1(q)];
      end
      for (int n = 0; n < 3; n++) begin
        for (int k = 0; k < 3; k++) begin
          ae_i = e2_r[n][ax1(k)][EW-1] ? EW'(-e2_r[n][ax1(k)]) : EW'(e2_r[n][ax1(k)]);
          ae_j = e2_r[n][ax2(k)][EW-1] ? EW'(-e2_r[n][ax2(k)]) : EW'(e2_r[n][ax2(k)]);
          ra3_r[n][k] <= ae_j * half_r[ax1(k)];
          rb3_r[n][k] <= ae_i * half_r[ax2(k)];
          for (int m = 0; m < 3; m++) begin
            pa3_r[n][k][m] <= e2_r[n][ax2(k)] * v2_r[m][ax1(k)];
            pb3_r[n][k][m] <= e2_r[n][ax1(k)] * v2_r[m][ax2(k)];
          end
        end
      end
    end
  end

  // stage 4: projections, radii, normal, plane bounds
  always_ff @(posedge clk) begin
    if (en) begin
      box4_r <= box3_r;
      for (int q = 0; q < 3; q++) begin
        nrm4_r[q] <= WW'(na3_r[q]) - WW'(nb3_r[q]);
        lo4_r[q]  <= -$signed(EW'(half_r[q])) - EW'(v03_r[q]);
        hi4_r[q]  <= $signed(EW'(half_r[q])) - EW'(v03_r[q]);
      end
      for (int n = 0; n < 3; n++) begin
        for (int k = 0; k < 3; k++) begin
          rad4_r[n][k] <= $signed(WW'(ra3_r[n][k]) + WW'(rb3_r[n][k]));
          for (int m = 0; m < 3; m++) begin
            p4_r[n][k][m] <= WW'(pa3_r[n][k][m]) - WW'(pb3_r[n][k][m]);
          end
        end
      end
    end
  end

  // stage 5: edge axis compares, split normal products
  always_comb begin
    logic all_hi, all_lo;
    edge5_nxt = 1'b0;
    for (int n = 0; n < 3; n++) begin
      for (int k = 0; k < 3; k++) begin
        all_hi = 1'b1;
        all_lo = 1'b1;
        for (int m = 0; m < 3; m++) begin
          all_hi = all_hi && (p4_r[n][k][m] > rad4_r[n][k]);
          all_lo = all_lo && (p4_r[n][k][m] < -rad4_r[n][k]);
        end
        edge5_nxt = edge5_nxt || all_hi || all_lo;
      end
    end
  end

  always_ff @(posedge clk) begin
    logic signed [EW-1:0] xl, xh;
    logic signed [NL:0]   nlo;
    logic signed [NHW-1:0] nhi;
    if (en) begin
      edge5_r <= edge5_nxt;
      box5_r  <= box4_r;
      nz5_r   <= (nrm4_r[0] == '0) && (nrm4_r[1] == '0) && (nrm4_r[2] == '0);
      for (int q = 0; q < 3; q++) begin
        xl  = (nrm4_r[q] > 0) ? lo4_r[q] : hi4_r[q];
        xh  = (nrm4_r[q] > 0) ? hi4_r[q] : lo4_r[q];
        nlo = $signed({1'b0, nrm4_r[q][NL-1:0]});
        nhi = nrm4_r[q][WW-1:NL];
        mll5_r[q] <= nlo * xl;
        mlh5_r[q] <= nhi * xl;
        mhl5_r[q] <= nlo * xh;
        mhh5_r[q] <= nhi * xh;
      end
    end
  end

  // stage 6: plane distances and result
  always_comb begin
    dmin_nxt = '0;
    dmax_nxt = '0;
    for (int q = 0; q < 3; q++) begin
      dmin_nxt = dmin_nxt + (DW'(mlh5_r[q]) <<< NL) + DW'(mll5_r[q]);
      dmax_nxt = dmax_nxt + (DW'(mhh5_r[q]) <<< NL) + DW'(mhl5_r[q]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_overlap_r <= !(edge5_r || box5_r || (dmin_nxt > 0) || (dmax_nxt < 0));
    end
  end

  a_edge_sep: assert property (@(posedge clk) disable iff (!rst_n)
    (en && vld5_r && edge5_r) |=> (out_valid_r && !out_overlap_r))
    else $error("edge axis separation lost");

  a_box_sep: assert property (@(posedge clk) disable iff (!rst_n)
    (en && vld5_r && box5_r) |=> (out_valid_r && !out_overlap_r))
    else $error("bounding range separation lost");

  a_flat: assert property (@(posedge clk) disable iff (!rst_n)
    (en && vld5_r && nz5_r && !edge5_r && !box5_r) |=> out_overlap_r)
    else $error("zero normal separated by plane test");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> ($stable(vld1_r) && $stable(vld3_r) && $stable(vld5_r)))
    else $error("pipeline moved during stall");

endmodule

// ===== sim/triangle_box_overlap_test_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_box_overlap_test_checker
// Watches the input, result and register ports of the overlap block and
// predicts each overlap flag with its own exact separating-axis test. It keeps
// a queue of expected flags and counts every mismatch, every unexpected word
// and every expected flag still waiting.
// ----------------------------------------------------------------------------
module triangle_box_overlap_test_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic signed [tbo_pkg::CW-1:0] in_a_x,
  input  logic signed [tbo_pkg::CW-1:0] in_a_y,
  input  logic signed [tbo_pkg::CW-1:0] in_a_z,
  input  logic signed [tbo_pkg::CW-1:0] in_b_x,
  input  logic signed [tbo_pkg::CW-1:0] in_b_y,
  input  logic signed [tbo_pkg::CW-1:0] in_b_z,
  input  logic signed [tbo_pkg::CW-1:0] in_c_x,
  input  logic signed [tbo_pkg::CW-1:0] in_c_y,
  input  logic signed [tbo_pkg::CW-1:0] in_c_z,
  input  logic signed [tbo_pkg::CW-1:0] in_center_x,
  input  logic signed [tbo_pkg::CW-1:0] in_center_y,
  input  logic signed [tbo_pkg::CW-1:0] in_center_z,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic                          out_overlap,
  input  logic                          cfg_we,
  input  logic [tbo_pkg::IW-1:0]        cfg_index,
  input  logic [tbo_pkg::HW-1:0]        cfg_wdata,
  output int                            fail_count,
  output int                            flags_pending
);
  import tbo_pkg::*;

  typedef logic signed [127:0] wide_t;

  logic [HW-1:0] half_ext [3];
  logic          overlap_q [$];
  int            fails;

  assign fail_count    = fails + overlap_q.size();
  assign flags_pending = overlap_q.size();

  function automatic wide_t mag(input wide_t x);
    return (x < 0) ? -x : x;
  endfunction

  // box axis k crossed with edge e
  function automatic bit edge_axis_splits(input wide_t v[3][3], input wide_t e[3],
                                          input wide_t h[3], input int k);
    int    i;
    int    j;
    wide_t p;
    wide_t lo;
    wide_t hi;
    wide_t rad;
    i = (k + 1) % 3;
    j = (k + 2) % 3;
    for (int n = 0; n < 3; n++) begin
      p = e[j] * v[n][i] - e[i] * v[n][j];
      if (n == 0 || p < lo) lo = p;
      if (n == 0 || p > hi) hi = p;
    end
    rad = mag(e[j]) * h[i] + mag(e[i]) * h[j];
    return (lo > rad) || (hi < -rad);
  endfunction

  function automatic logic tri_box_overlap(input logic signed [CW-1:0] w[12],
                                           input logic [HW-1:0] hs[3]);
    wide_t v[3][3];
    wide_t e[3][3];
    wide_t h[3];
    wide_t nrm[3];
    wide_t lo;
    wide_t hi;
    wide_t t;
    wide_t dmin;
    wide_t dmax;
    int    i;
    int    j;
    for (int q = 0; q < 3; q++) begin
      h[q] = wide_t'({1'b0, hs[q]});
      for (int n = 0; n < 3; n++)
        v[n][q] = wide_t'(w[n*3+q]) - wide_t'(w[9+q]);
    end
    for (int q = 0; q < 3; q++) begin
      e[0][q] = v[1][q] - v[0][q];
      e[1][q] = v[2][q] - v[1][q];
      e[2][q] = v[0][q] - v[2][q];
    end
    for (int n = 0; n < 3; n++)
      for (int k = 0; k < 3; k++)
        if (edge_axis_splits(v, e[n], h, k)) return 1'b0;
    for (int q = 0; q < 3; q++) begin
      lo = v[0][q];
      hi = v[0][q];
      for (int n = 1; n < 3; n++) begin
        if (v[n][q] < lo) lo = v[n][q];
        if (v[n][q] > hi) hi = v[n][q];
      end
      if (lo > h[q] || hi < -h[q]) return 1'b0;
    end
    for (int q = 0; q < 3; q++) begin
      i = (q + 1) % 3;
      j = (q + 2) % 3;
      nrm[q] = e[0][i] * e[1][j] - e[0][j] * e[1][i];
    end
    dmin = 0;
    dmax = 0;
    for (int q = 0; q < 3; q++) begin
      lo = -h[q] - v[0][q];
      hi = h[q] - v[0][q];
      if (!(nrm[q] > 0)) begin
        t  = lo;
        lo = hi;
        hi = t;
      end
      dmin = dmin + nrm[q] * lo;
      dmax = dmax + nrm[q] * hi;
    end
    if (dmin > 0) return 1'b0;
    return (dmax >= 0);
  endfunction

  always @(posedge clk) begin
    logic signed [CW-1:0] word [12];
    logic                 want;
    if (!rst_n) begin
      for (int q = 0; q < 3; q++) half_ext[q] = HW'(32768);
      overlap_q.delete();
      fails = 0;
    end else begin
      if (in_valid && in_ready) begin
        word = '{in_a_x, in_a_y, in_a_z, in_b_x, in_b_y, in_b_z,
                 in_c_x, in_c_y, in_c_z, in_center_x, in_center_y, in_center_z};
        overlap_q.push_back(tri_box_overlap(word, half_ext));
      end
      if (out_valid && out_ready) begin
        if (overlap_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected word, overlap %0b", $time, out_overlap);
        end else begin
          want = overlap_q.pop_front();
          if (want !== out_overlap) begin
            fails++;
            $display("%0t: overlap expected %0b actual %0b", $time, want, out_overlap);
          end
        end
      end
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_HALF_X: half_ext[0] = cfg_wdata;
          REG_HALF_Y: half_ext[1] = cfg_wdata;
          REG_HALF_Z: half_ext[2] = cfg_wdata;
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== sim/triangle_box_overlap_test_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_box_overlap_test_tb
// Drives triangle/box words into the overlap block: directed extremes,
// touching and degenerate triangles, then random triangles, mostly near the
// box, under several half extent settings and idle and stall patterns. The
// checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module triangle_box_overlap_test_tb;
  import tbo_pkg::*;

  typedef logic signed [CW-1:0] crd_t;

  localparam logic [IW-1:0] REG_UNUSED = 2'd3;
  localparam int            MAX_CYCLES = 400000;
  localparam crd_t          CMIN = crd_t'(32'h8000_0000);
  localparam crd_t          CMAX = crd_t'(32'h7fff_ffff);

  logic          clk = 1'b0;
  logic          rst_n;
  logic          in_valid;
  logic          in_ready;
  crd_t          in_a_x, in_a_y, in_a_z, in_b_x, in_b_y, in_b_z;
  crd_t          in_c_x, in_c_y, in_c_z, in_center_x, in_center_y, in_center_z;
  logic          out_valid;
  logic          out_ready;
  logic          out_overlap;
  logic          cfg_we;
  logic [IW-1:0] cfg_index;
  logic [HW-1:0] cfg_wdata;
  int            fail_count;
  int            flags_pending;
  int            send_idle_pct;
  int            recv_stall_pct;
  int            cycles;
  longint        box_span;
  crd_t          word [12];

  always #10 clk = ~clk;

  triangle_box_overlap_test dut (.*);

  triangle_box_overlap_test_checker chk (.*);

  always @(posedge clk)
    out_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("** triangle_box_overlap_test: FAILED **");
      $finish;
    end
  end

  task automatic send_word();
    logic hit;
    in_valid    <= 1'b1;
    in_a_x      <= word[0];
    in_a_y      <= word[1];
    in_a_z      <= word[2];
    in_b_x      <= word[3];
    in_b_y      <= word[4];
    in_b_z      <= word[5];
    in_c_x      <= word[6];
    in_c_y      <= word[7];
    in_c_z      <= word[8];
    in_center_x <= word[9];
    in_center_y <= word[10];
    in_center_z <= word[11];
    do begin
      @(negedge clk);
      hit = in_ready;
      @(posedge clk);
    end while (!hit);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (flags_pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IW-1:0] idx, input logic [HW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_box(input logic [HW-1:0] hx, input logic [HW-1:0] hy,
                         input logic [HW-1:0] hz);
    drain();
    write_reg(REG_HALF_X, hx);
    write_reg(REG_HALF_Y, hy);
    write_reg(REG_HALF_Z, hz);
    box_span = hx;
    if (hy > box_span) box_span = hy;
    if (hz > box_span) box_span = hz;
  endtask

  task automatic put(input crd_t ax, input crd_t ay, input crd_t az,
                     input crd_t bx, input crd_t by, input crd_t bz,
                     input crd_t cx, input crd_t cy, input crd_t cz);
    word = '{ax, ay, az, bx, by, bz, cx, cy, cz, 0, 0, 0};
    send_word();
  endtask

  task automatic random_word();
    longint s;
    int     mode;
    mode = $urandom_range(9);
    if (mode == 0) begin
      for (int n = 0; n < 12; n++) word[n] = $urandom;
    end else begin
      for (int q = 0; q < 3; q++)
        word[9+q] = ($urandom_range(3) == 0) ? crd_t'($urandom)
                                             : crd_t'($urandom_range(0, 1 << 20)) - (1 << 19);
      if ($urandom_range(2) == 0) s = longint'(1) << $urandom_range(0, 30);
      else s = (box_span * $urandom_range(1, 6)) / 2 + 1;
      if (s > (longint'(1) << 30)) s = longint'(1) << 30;
      for (int n = 0; n < 9; n++)
        word[n] = crd_t'(longint'(word[9 + n % 3]) + longint'($urandom_range(0, 2 * s)) - s);
      if (mode == 1) for (int q = 0; q < 3; q++) word[3+q] = word[q];
      if (mode == 2) for (int q = 0; q < 3; q++) word[6+q] = word[3+q] + (word[3+q] - word[q]);
    end
    send_word();
  endtask

  initial begin
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= REG_HALF_X;
    cfg_wdata      <= '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    box_span       = 32768;
    for (int n = 0; n < 12; n++) word[n] = '0;
    in_a_x <= 0; in_a_y <= 0; in_a_z <= 0; in_b_x <= 0; in_b_y <= 0; in_b_z <= 0;
    in_c_x <= 0; in_c_y <= 0; in_c_z <= 0;
    in_center_x <= 0; in_center_y <= 0; in_center_z <= 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words at reset half extents (0.5)
    put(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN);
    put(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
    put(CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN);
    put(0, 0, 0, 0, 0, 0, 0, 0, 0);
    put(32768, 32768, 32768, 200000, 32768, 90000, 90000, 200000, 40000);
    put(32769, 32769, 32769, 200000, 32769, 90000, 90000, 200000, 40000);
    put(-131072, -131072, 32768, 131072, -131072, 32768, 0, 131072, 32768);
    put(-131072, -131072, 32769, 131072, -131072, 32769, 0, 131072, 32769);
    put(-131072, 0, 0, 131072, 0, 0, 0, 0, 0);
    put(-131072, 0, 40000, 131072, 0, 40000, 131072, 0, 40000);
    put(-131072, 65536, 0, 65536, -131072, 0, 65536, 65536, 0);
    put(-131072, 70000, 0, 70000, -131072, 0, 70000, 70000, 0);
    put(-200000, 0, 40000, 0, 200000, 40000, 0, 0, 200000);
    put(40000, 40000, 40000, 50000, 40000, 40000, 40000, 50000, 40000);
    word = '{0, 0, 0, 0, 0, 0, 0, 0, 0, CMIN, CMAX, CMIN};
    send_word();
    word = '{CMIN, CMAX, 0, CMAX, CMIN, 0, 0, 0, CMAX, CMAX, CMIN, CMAX};
    send_word();
    drain();
    write_reg(REG_UNUSED, '1);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_box(HW'(32768), HW'(32768), HW'(32768));
        1: set_box('0, '0, '0);
        2: set_box('1, '1, '1);
        3: set_box(HW'(65536), HW'(1), HW'(1 << 20));
        4: set_box(HW'($urandom), HW'($urandom_range(1 << 18)), HW'($urandom_range(1 << 16)));
        default: set_box(HW'($urandom_range(1 << 17)), HW'(0), '1);
      endcase
      for (int n = 0; n < 224; n++) begin
        case ((n / 56 + ph) % 4)
          0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
          1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
          2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
          default: begin send_idle_pct = 16; recv_stall_pct = 16; end
        endcase
        random_word();
      end
    end

    in_valid <= 1'b0;
    while (flags_pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("** triangle_box_overlap_test: PASSED **");
    else $display("** triangle_box_overlap_test: FAILED **");
    $finish;
  end

endmodule
